// ===== design/aft_pkg.sv =====
// Shared types and constants of the animation frame timer.
package aft_pkg;

	localparam int MAX_FRAMES_DEF = 256;
	localparam int FRAME_CAP      = 256;
	localparam int FRAME_W        = 8;
	localparam int COUNT_W        = 9;
	localparam int DUR_W          = 16;
	localparam int CFG_IDX_W      = 2;
	localparam logic [DUR_W-1:0] RESET_DURATION = 16'd100;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_TOTAL      = 2'd0,
		REG_LOOP_ENABLE      = 2'd1,
		REG_DEFAULT_DURATION = 2'd2,
		REG_TABLE_ENABLE     = 2'd3
	} cfg_reg_t;

	typedef enum logic {
		CMD_ADVANCE = 1'b0,
		CMD_WRITE   = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [COUNT_W-1:0] frame_total;
		logic               loop_enable;
		logic [DUR_W-1:0]   default_duration;
		logic               table_enable;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_RUN  = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

endpackage

// ===== design/aft_if.sv =====
// Valid/ready channel interfaces for command beats and result beats.
interface aft_req_if;
	logic                          valid;
	logic                          ready;
	logic                          cmd;
	logic [aft_pkg::DUR_W-1:0]     delta_ms;
	logic [aft_pkg::FRAME_W-1:0]   entry_index;
	logic [aft_pkg::DUR_W-1:0]     entry_duration;

	modport source (output valid, cmd, delta_ms, entry_index, entry_duration, input ready);
	modport sink (input valid, cmd, delta_ms, entry_index, entry_duration, output ready);
endinterface

interface aft_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [aft_pkg::FRAME_W-1:0]   frame_position;
	logic [aft_pkg::DUR_W-1:0]     time_in_frame;

	modport source (output valid, frame_position, time_in_frame, input ready);
	modport sink (input valid, frame_position, time_in_frame, output ready);
endinterface

// ===== design/aft_table.sv =====
// Per-frame duration memory: one write port, one registered read port.
module aft_table #(
	parameter int DEPTH = aft_pkg::FRAME_CAP,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      wr_en,
	input  logic [AW-1:0]             wr_addr,
	input  logic [aft_pkg::DUR_W-1:0] wr_data,
	input  logic [AW-1:0]             rd_addr,
	output logic [aft_pkg::DUR_W-1:0] rd_data
);

	logic [aft_pkg::DUR_W-1:0] mem [DEPTH];
	logic [aft_pkg::DUR_W-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		rd_data_q <= mem[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ===== design/aft_ctrl.sv =====
// Sequencer: frame state, one frame step per cycle against the table, result register.
module aft_ctrl #(
	parameter int DEPTH = aft_pkg::FRAME_CAP,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  aft_pkg::cfg_t             cfg,
	aft_req_if.sink                   req,
	aft_rsp_if.source                 rsp,
	output logic                      wr_en,
	output logic [AW-1:0]             wr_addr,
	output logic [aft_pkg::DUR_W-1:0] wr_data,
	output logic [AW-1:0]             rd_addr,
	input  logic [aft_pkg::DUR_W-1:0] rd_data
);

	localparam logic [aft_pkg::COUNT_W-1:0] DEPTH_C = aft_pkg::COUNT_W'(DEPTH);

	aft_pkg::state_t state_q;

	logic [aft_pkg::FRAME_W-1:0] cf_q;
	logic [aft_pkg::DUR_W-1:0]   fe_q;
	logic [aft_pkg::DUR_W-1:0]   rem_q;
	logic                        inr_s1;
	logic                        out_valid_q;
	logic [aft_pkg::FRAME_W-1:0] out_frame_q;
	logic [aft_pkg::DUR_W-1:0]   out_time_q;

	logic                        acc;
	logic                        out_free;
	logic [aft_pkg::COUNT_W-1:0] eff_count;
	logic [aft_pkg::DUR_W-1:0]   dur_sel;
	logic [aft_pkg::DUR_W-1:0]   ms_to_end;
	logic [aft_pkg::DUR_W-1:0]   rem_next;
	logic                        step_over;
	logic [aft_pkg::COUNT_W-1:0] cf_inc;
	logic                        hold_last;
	logic [aft_pkg::FRAME_W-1:0] last_frame;
	logic [aft_pkg::FRAME_W-1:0] next_cf;
	logic [aft_pkg::FRAME_W-1:0] rd_frame;
	logic                        no_work;

	assign req.ready = (state_q == aft_pkg::ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign out_free  = !out_valid_q || rsp.ready;

	assign eff_count = (cfg.frame_total > DEPTH_C) ? DEPTH_C : cfg.frame_total;
	assign no_work   = (eff_count <= aft_pkg::COUNT_W'(1)) || (req.delta_ms == '0);

	assign dur_sel = (cfg.table_enable && inr_s1 && (rd_data != '0)) ? rd_data
		: cfg.default_duration;
	assign ms_to_end = (fe_q < dur_sel) ? (dur_sel - fe_q) : '0;
	assign step_over = (rem_q >= ms_to_end);
	assign rem_next  = rem_q - ms_to_end;

	assign cf_inc     = {1'b0, cf_q} + aft_pkg::COUNT_W'(1);
	assign last_frame = aft_pkg::FRAME_W'(eff_count - aft_pkg::COUNT_W'(1));
	assign hold_last  = !(cf_inc < eff_count) && !cfg.loop_enable;

	always_comb begin
		priority if (cf_inc < eff_count) begin
			next_cf = cf_inc[aft_pkg::FRAME_W-1:0];
		end else if (cfg.loop_enable) begin
			next_cf = '0;
		end else begin
			next_cf = last_frame;
		end
	end

	// next frame's duration is fetched while this one is stepped
	assign rd_frame = (state_q == aft_pkg::ST_RUN) ? next_cf : cf_q;
	assign rd_addr  = rd_frame[AW-1:0];

	always_ff @(posedge clk) begin
		inr_s1 <= ({1'b0, rd_frame} < DEPTH_C);
	end

	assign wr_en   = acc && (req.cmd == aft_pkg::CMD_WRITE)
		&& ({1'b0, req.entry_index} < DEPTH_C);
	assign wr_addr = req.entry_index[AW-1:0];
	assign wr_data = req.entry_duration;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aft_pkg::ST_IDLE;
			cf_q    <= '0;
			fe_q    <= '0;
		end else begin
			unique case (state_q)
				aft_pkg::ST_IDLE: begin
					if (acc) begin
						if (req.cmd == aft_pkg::CMD_WRITE || no_work) begin
							state_q <= aft_pkg::ST_EMIT;
						end else begin
							state_q <= aft_pkg::ST_RUN;
						end
					end
				end
				aft_pkg::ST_RUN: begin
					priority if (dur_sel == '0) begin
						state_q <= aft_pkg::ST_EMIT;
					end else if (!step_over) begin
						fe_q    <= fe_q + rem_q;
						state_q <= aft_pkg::ST_EMIT;
					end else if (hold_last) begin
						cf_q    <= last_frame;
						fe_q    <= dur_sel - aft_pkg::DUR_W'(1);
						state_q <= aft_pkg::ST_EMIT;
					end else begin
						cf_q <= next_cf;
						fe_q <= '0;
						if (rem_next == '0) begin
							state_q <= aft_pkg::ST_EMIT;
						end
					end
				end
				aft_pkg::ST_EMIT: begin
					if (out_free) begin
						state_q <= aft_pkg::ST_IDLE;
					end
				end
				default: state_q <= aft_pkg::ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == aft_pkg::ST_IDLE && acc) begin
			rem_q <= req.delta_ms;
		end else if (state_q == aft_pkg::ST_RUN) begin
			rem_q <= rem_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == aft_pkg::ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == aft_pkg::ST_EMIT && out_free) begin
			out_frame_q <= cf_q;
			out_time_q  <= fe_q;
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.frame_position = out_frame_q;
	assign rsp.time_in_frame  = out_time_q;

endmodule

// ===== design/animation_frame_timer_core.sv =====
// Top level of the animation frame timer: configuration registers, sequencer, duration table.
//
// Usage
//   req carries command beats: cmd advance (delta_ms) or table write
//   (entry_index, entry_duration). rsp returns one beat per command with the
//   frame index and the milliseconds spent in it after that command.
//   Registers are written through cfg_wr_en/cfg_index/cfg_data while idle.
// Throughput
//   A table write, or an advance that does no work, goes from acceptance straight
//   to the emit state. An advance steps one frame per cycle through the frames it
//   visits, looking up the duration of each; the single read port of the duration
//   table sets this one-frame-per-cycle pace.
//   One command is worked on at a time; req.ready is high only when idle.
// Reset
//   arst_n clears frame index and time to 0 and loads the register defaults
//   (frame_total 0, no loop, default duration 100 ms, table off). The table is
//   not cleared: an entry must be written before the table reads it.
// Stall
//   The result sits in an output register; a new command is taken while it
//   waits, and the next result waits until rsp.ready frees the register.
module animation_frame_timer_core #(
	parameter int MAX_FRAMES = aft_pkg::MAX_FRAMES_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	aft_req_if.sink                       req,
	aft_rsp_if.source                     rsp,
	input  logic                          cfg_wr_en,
	input  logic [aft_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [aft_pkg::DUR_W-1:0]     cfg_data
);

	localparam int DEPTH = (MAX_FRAMES < aft_pkg::FRAME_CAP) ? MAX_FRAMES : aft_pkg::FRAME_CAP;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	aft_pkg::cfg_t cfg_q;

	logic                      wr_en;
	logic [AW-1:0]             wr_addr;
	logic [aft_pkg::DUR_W-1:0] wr_data;
	logic [AW-1:0]             rd_addr;
	logic [aft_pkg::DUR_W-1:0] rd_data;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.frame_total      <= '0;
			cfg_q.loop_enable      <= 1'b0;
			cfg_q.default_duration <= aft_pkg::RESET_DURATION;
			cfg_q.table_enable     <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (aft_pkg::cfg_reg_t'(cfg_index))
				aft_pkg::REG_FRAME_TOTAL:
					cfg_q.frame_total <= cfg_data[aft_pkg::COUNT_W-1:0];
				aft_pkg::REG_LOOP_ENABLE:      cfg_q.loop_enable      <= cfg_data[0];
				aft_pkg::REG_DEFAULT_DURATION: cfg_q.default_duration <= cfg_data;
				aft_pkg::REG_TABLE_ENABLE:     cfg_q.table_enable     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	aft_ctrl #(
		.DEPTH (DEPTH)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.req     (req),
		.rsp     (rsp),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	aft_table #(
		.DEPTH (DEPTH)
	) u_table (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req.valid && req.ready |=> !req.ready)
		else $error("command accepted while a previous one is in flight");

	a_frame_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> ({1'b0, rsp.frame_position} < aft_pkg::COUNT_W'(DEPTH)))
		else $error("frame position beyond table depth");

	a_table_quiet_when_busy: assert property (@(posedge clk) disable iff (!arst_n)
		!req.ready |-> !wr_en)
		else $error("table written while an advance is running");

endmodule

// ===== sim/tb.sv =====
// Self-checking testbench of the animation frame timer: directed cases, table fill, random phases.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TABLE_SIZE = 256;
	localparam int WATCHDOG_CYCLES = 12_000_000;
	localparam int DW = aft_pkg::DUR_W;
	localparam int FW = aft_pkg::FRAME_W;

	typedef struct packed {
		logic [FW-1:0] pos;
		logic [DW-1:0] ms;
	} frame_state_t;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_wr_en;
	logic [aft_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [DW-1:0]                 cfg_data;

	aft_req_if req_if ();
	aft_rsp_if rsp_if ();

	animation_frame_timer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req_if),
		.rsp       (rsp_if),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// timer state as the block should hold it
	int unsigned        frame_now;
	int unsigned        ms_now;
	logic [DW-1:0]      dur_tab [TABLE_SIZE];
	int unsigned        frames_cfg;
	logic               loop_cfg;
	int unsigned        dflt_cfg;
	logic               tab_cfg;

	frame_state_t       exp_frames [$];

	bit                 steady;
	int unsigned        el_cap;
	bit                 big_ok;
	int unsigned        n_adv;
	int unsigned        n_wr;
	int unsigned        n_reg_wr;
	int unsigned        n_checked;
	int unsigned        n_err;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		repeat (WATCHDOG_CYCLES) @(posedge clk);
		$display("Timeout: %0d results still outstanding", exp_frames.size());
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		rsp_if.ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_if.ready <= steady || ($urandom_range(99) >= 32);
		end
	end

	always @(posedge clk) begin
		frame_state_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (exp_frames.size() == 0) begin
				n_err++;
				if (n_err <= 10)
					$display("Unexpected result beat: frame %0d time %0d",
						rsp_if.frame_position, rsp_if.time_in_frame);
			end else begin
				want = exp_frames.pop_front();
				n_checked++;
				if (rsp_if.frame_position !== want.pos
						|| rsp_if.time_in_frame !== want.ms) begin
					n_err++;
					if (n_err <= 10)
						$display("Mismatch on result %0d: frame exp %0d got %0d, %s %0d got %0d",
							n_checked, want.pos, rsp_if.frame_position, "time exp",
							want.ms, rsp_if.time_in_frame);
				end
			end
		end
	end

	function automatic int unsigned dur_of_frame(int unsigned f);
		if (tab_cfg && f < TABLE_SIZE && dur_tab[f] != '0)
			return 32'(dur_tab[f]);
		return dflt_cfg;
	endfunction

	function automatic frame_state_t step_timer(aft_pkg::cmd_t c, logic [DW-1:0] el,
			logic [FW-1:0] idx, logic [DW-1:0] dur);
		int unsigned  count;
		int unsigned  left;
		int unsigned  d;
		int unsigned  gap;
		frame_state_t res;
		count = (frames_cfg > TABLE_SIZE) ? TABLE_SIZE : frames_cfg;
		if (c == aft_pkg::CMD_WRITE) begin
			dur_tab[idx] = dur;
		end else if (count > 1 && el != '0) begin
			left = 32'(el);
			while (left > 0) begin
				d = dur_of_frame(frame_now);
				if (d == 0)
					break;
				gap = (ms_now < d) ? d - ms_now : 0;
				if (left < gap) begin
					ms_now += left;
					break;
				end
				left -= gap;
				ms_now = 0;
				if (frame_now + 1 < count) begin
					frame_now++;
				end else if (loop_cfg) begin
					frame_now = 0;
				end else begin
					frame_now = count - 1;
					ms_now = d - 1;
					break;
				end
			end
		end
		res.pos = frame_now[FW-1:0];
		res.ms = ms_now[DW-1:0];
		return res;
	endfunction

	function automatic logic [DW-1:0] rand_elapsed();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 4 && big_ok)
			return DW'($urandom_range(65535));
		if (r < 14)
			return DW'($urandom_range(3));
		return DW'($urandom_range(el_cap));
	endfunction

	function automatic logic [DW-1:0] rand_duration();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 10)
			return '0;
		if (r < 15)
			return DW'($urandom_range(1, 3));
		if (r < 25)
			return DW'($urandom_range(65535));
		return DW'($urandom_range(20, 400));
	endfunction

	// called at a falling edge; returns at the falling edge after the beat is taken
	task automatic send_beat(aft_pkg::cmd_t c, logic [DW-1:0] el, logic [FW-1:0] idx,
			logic [DW-1:0] dur);
		frame_state_t e;
		while (!steady && $urandom_range(99) < 32) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.cmd <= c;
		req_if.delta_ms <= el;
		req_if.entry_index <= idx;
		req_if.entry_duration <= dur;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		@(negedge clk);
		e = step_timer(c, el, idx, dur);
		exp_frames = {exp_frames, e};
		if (c == aft_pkg::CMD_WRITE)
			n_wr++;
		else
			n_adv++;
	endtask

	task automatic drain_results();
		req_if.valid <= 1'b0;
		while (exp_frames.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(aft_pkg::cfg_reg_t r, logic [DW-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_index <= r;
		cfg_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
		n_reg_wr++;
		case (r)
			aft_pkg::REG_FRAME_TOTAL:      frames_cfg = 32'(v[aft_pkg::COUNT_W-1:0]);
			aft_pkg::REG_LOOP_ENABLE:      loop_cfg = v[0];
			aft_pkg::REG_DEFAULT_DURATION: dflt_cfg = 32'(v);
			aft_pkg::REG_TABLE_ENABLE:     tab_cfg = v[0];
			default: ;
		endcase
	endtask

	task automatic apply_settings(int unsigned tot, bit lp, int unsigned dd, bit te);
		drain_results();
		write_reg(aft_pkg::REG_FRAME_TOTAL, DW'(tot));
		write_reg(aft_pkg::REG_LOOP_ENABLE, DW'(lp));
		write_reg(aft_pkg::REG_DEFAULT_DURATION, DW'(dd));
		write_reg(aft_pkg::REG_TABLE_ENABLE, DW'(te));
		el_cap = (dd < 20) ? 60 : 1500;
		big_ok = (dd >= 20);
	endtask

	task automatic test_idle_counts();
		send_beat(aft_pkg::CMD_ADVANCE, 16'hFFFF, 8'h00, 16'h0000);
		drain_results();
		write_reg(aft_pkg::REG_FRAME_TOTAL, 16'd1);
		send_beat(aft_pkg::CMD_ADVANCE, 16'd500, 8'hFF, 16'hFFFF);
	endtask

	task automatic test_hold_last();
		apply_settings(4, 1'b0, 100, 1'b0);
		send_beat(aft_pkg::CMD_ADVANCE, 16'd0, 8'h00, 16'h0000);
		send_beat(aft_pkg::CMD_ADVANCE, 16'd50, 8'h00, 16'h0000);
		send_beat(aft_pkg::CMD_ADVANCE, 16'd49, 8'h00, 16'h0000);
		send_beat(aft_pkg::CMD_ADVANCE, 16'd1, 8'h00, 16'h0000);
		send_beat(aft_pkg::CMD_ADVANCE, 16'd250, 8'h00, 16'h0000);
		send_beat(aft_pkg::CMD_ADVANCE, 16'hFFFF, 8'h00, 16'h0000);
	endtask

	task automatic test_loop_wrap();
		apply_settings(511, 1'b1, 100, 1'b0);
		send_beat(aft_pkg::CMD_ADVANCE, 16'hFFFF, 8'h00, 16'h0000);
		send_beat(aft_pkg::CMD_ADVANCE, 16'd100, 8'h00, 16'h0000);
	endtask

	task automatic test_zero_duration();
		drain_results();
		write_reg(aft_pkg::REG_DEFAULT_DURATION, 16'd0);
		send_beat(aft_pkg::CMD_ADVANCE, 16'd300, 8'h00, 16'h0000);
	endtask

	task automatic test_time_past_end();
		apply_settings(8, 1'b0, 1000, 1'b0);
		send_beat(aft_pkg::CMD_ADVANCE, 16'd900, 8'h00, 16'h0000);
		drain_results();
		write_reg(aft_pkg::REG_DEFAULT_DURATION, 16'd100);
		send_beat(aft_pkg::CMD_ADVANCE, 16'd5, 8'h00, 16'h0000);
	endtask

	task automatic test_frame_past_count();
		apply_settings(256, 1'b0, 100, 1'b0);
		send_beat(aft_pkg::CMD_ADVANCE, 16'd20000, 8'h00, 16'h0000);
		drain_results();
		write_reg(aft_pkg::REG_FRAME_TOTAL, 16'd10);
		send_beat(aft_pkg::CMD_ADVANCE, 16'd100, 8'h00, 16'h0000);
		apply_settings(256, 1'b1, 100, 1'b0);
		send_beat(aft_pkg::CMD_ADVANCE, 16'd15000, 8'h00, 16'h0000);
		drain_results();
		write_reg(aft_pkg::REG_FRAME_TOTAL, 16'd10);
		send_beat(aft_pkg::CMD_ADVANCE, 16'd150, 8'h00, 16'h0000);
	endtask

	// only the current frame and frames 0..3 are reachable while the table is on
	task automatic test_table_read();
		int unsigned here;
		drain_results();
		here = frame_now;
		send_beat(aft_pkg::CMD_WRITE, 16'h0000, FW'(here), 16'd7);
		send_beat(aft_pkg::CMD_WRITE, 16'hFFFF, 8'd0, 16'd30);
		send_beat(aft_pkg::CMD_WRITE, 16'h0000, 8'd1, 16'd0);
		send_beat(aft_pkg::CMD_WRITE, 16'h0000, 8'd2, 16'hFFFF);
		send_beat(aft_pkg::CMD_WRITE, 16'h0000, 8'd3, 16'd1);
		send_beat(aft_pkg::CMD_WRITE, 16'h0000, 8'd255, 16'hFFFF);
		apply_settings(4, 1'b1, 100, 1'b1);
		send_beat(aft_pkg::CMD_ADVANCE, 16'd20, 8'h00, 16'h0000);
		send_beat(aft_pkg::CMD_ADVANCE, 16'd40, 8'h00, 16'h0000);
		send_beat(aft_pkg::CMD_ADVANCE, 16'd80, 8'h00, 16'h0000);
		send_beat(aft_pkg::CMD_ADVANCE, 16'hFFFF, 8'h00, 16'h0000);
		drain_results();
		write_reg(aft_pkg::REG_TABLE_ENABLE, 16'd0);
	endtask

	task automatic test_table_load();
		int unsigned order [TABLE_SIZE];
		int unsigned j;
		int unsigned t;
		apply_settings(256, 1'b1, 100, 1'b0);
		for (int i = 0; i < TABLE_SIZE; i++)
			order[i] = i;
		for (int i = TABLE_SIZE - 1; i > 0; i--) begin
			j = $urandom_range(i);
			t = order[i];
			order[i] = order[j];
			order[j] = t;
		end
		for (int i = 0; i < TABLE_SIZE; i++) begin
			send_beat(aft_pkg::CMD_WRITE, DW'($urandom_range(65535)), FW'(order[i]),
				rand_duration());
			if (i % 3 == 0)
				send_beat(aft_pkg::CMD_ADVANCE, rand_elapsed(), FW'($urandom_range(255)),
					DW'($urandom_range(65535)));
		end
	endtask

	task automatic test_random_phases();
		int unsigned tot;
		int unsigned dd;
		bit          lp;
		bit          te;
		for (int p = 0; p < 12; p++) begin
			case (p)
				0: begin tot = 256; lp = 1'b1; dd = 100;   te = 1'b1; end
				1: begin tot = 511; lp = 1'b0; dd = 65535; te = 1'b0; end
				2: begin tot = 0;   lp = 1'b1; dd = 1;     te = 1'b0; end
				3: begin tot = 1;   lp = 1'b0; dd = 100;   te = 1'b1; end
				4: begin tot = 2;   lp = 1'b0; dd = 0;     te = 1'b1; end
				5: begin tot = 257; lp = 1'b1; dd = 1;     te = 1'b1; end
				default: begin
					tot = ($urandom_range(3) == 0) ? $urandom_range(511) : $urandom_range(2, 40);
					dd = ($urandom_range(3) == 0) ? $urandom_range(65535) : $urandom_range(10, 400);
					lp = 1'($urandom_range(1));
					te = 1'($urandom_range(1));
				end
			endcase
			apply_settings(tot, lp, dd, te);
			steady = (p == 0);
			for (int k = 0; k < 58; k++) begin
				if (k == 29 && p % 3 == 0)
					drain_results();
				if ($urandom_range(99) < 15)
					send_beat(aft_pkg::CMD_WRITE, DW'($urandom_range(65535)),
						FW'($urandom_range(255)), rand_duration());
				else
					send_beat(aft_pkg::CMD_ADVANCE, rand_elapsed(),
						FW'($urandom_range(255)), DW'($urandom_range(65535)));
			end
			steady = 1'b0;
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = aft_pkg::REG_FRAME_TOTAL;
		cfg_data = '0;
		req_if.valid = 1'b0;
		req_if.cmd = aft_pkg::CMD_ADVANCE;
		req_if.delta_ms = '0;
		req_if.entry_index = '0;
		req_if.entry_duration = '0;
		frame_now = 0;
		ms_now = 0;
		frames_cfg = 0;
		loop_cfg = 1'b0;
		dflt_cfg = 32'(aft_pkg::RESET_DURATION);
		tab_cfg = 1'b0;
		steady = 1'b0;
		el_cap = 1500;
		big_ok = 1'b1;
		n_adv = 0;
		n_wr = 0;
		n_reg_wr = 0;
		n_checked = 0;
		n_err = 0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_idle_counts();
		test_hold_last();
		test_loop_wrap();
		test_zero_duration();
		test_time_past_end();
		test_frame_past_count();
		test_table_read();
		test_table_load();
		test_random_phases();

		drain_results();
		repeat (20) @(negedge clk);
		$display("Run covered %0d advance beats and %0d table writes across %0d register writes,",
			n_adv, n_wr, n_reg_wr);
		$display("including hold, wrap, zero duration and out-of-range frame cases; %0d checked.",
			n_checked);
		if (n_err == 0 && exp_frames.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
